// ----- hdl/dd_odo_pkg.sv -----
// Shared types, constants and the CORDIC angle table of the wheel odometry block.
package dd_odo_pkg;

    localparam int ANGLE_BITS_DEF   = 24;
    localparam int CORDIC_STEPS_DEF = 24;

    // Datapath widths.
    localparam int DATA_W     = 60;  // CORDIC x and y
    localparam int TRAVEL_W   = 56;  // ticks times distance per tick
    localparam int SUM_W      = 57;  // sum or difference of two travels
    localparam int DIVIDEND_W = 50;  // truncated travel times 1000
    localparam int DT_W       = 32;  // elapsed milliseconds
    localparam int POS_W      = 48;

    localparam logic [16:0] GAIN_Q16 = 17'd39797;
    localparam logic [9:0]  MS_PER_S = 10'd1000;

    typedef enum logic [1:0] {
        REG_DIST_PER_TICK = 2'd0,
        REG_WHEEL_BASE    = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        CORDIC_VECTOR = 1'b0,
        CORDIC_ROTATE = 1'b1
    } cordic_mode_t;

    typedef struct packed {
        logic         start;
        cordic_mode_t mode;
    } cordic_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_SPD_L,
        ST_DIV_L,
        ST_SPD_R,
        ST_DIV_R,
        ST_VEC,
        ST_VEC_WAIT,
        ST_ROT_PREP,
        ST_ROT,
        ST_ROT_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count_raw;
        logic        [31:0] now_ms;
    } cmd_word_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic        [23:0] heading;
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
        logic               no_elapsed_time;
    } res_word_t;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURN32 [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // Table entry rounded to the given angle width.
    function automatic logic [32:0] step_angle(input int idx, input int abits);
        logic [32:0] e;
        e = {1'b0, ATAN_TURN32[idx[4:0]]};
        if (abits < 32)
        begin
            e = (e + (33'd1 << (31 - abits))) >> (32 - abits);
        end
        return e;
    endfunction

endpackage

// ----- hdl/dd_odo_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module dd_odo_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [dd_odo_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [dd_odo_pkg::DT_W-1:0]         divisor,
    output logic                                done,
    output logic [dd_odo_pkg::DIVIDEND_W-1:0]   quotient
);
    import dd_odo_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DT_W-1:0]       rem_reg, rem_next;
    logic [DT_W-1:0]       div_reg, div_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DT_W:0]         trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            div_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = DT_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = DT_W'(trial);
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/dd_odo_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle, in vectoring or rotation mode.
module dd_odo_cordic
#(
    parameter int ANGLE_BITS   = dd_odo_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = dd_odo_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dd_odo_pkg::cordic_ctrl_t             ctrl,
    input  logic signed [dd_odo_pkg::DATA_W-1:0] x_in,
    input  logic signed [dd_odo_pkg::DATA_W-1:0] y_in,
    input  logic signed [ANGLE_BITS+1:0]         z_in,
    output logic                                 done,
    output logic signed [dd_odo_pkg::DATA_W-1:0] x_out,
    output logic signed [dd_odo_pkg::DATA_W-1:0] y_out,
    output logic signed [ANGLE_BITS+1:0]         z_out
);
    import dd_odo_pkg::*;

    localparam int Z_W   = ANGLE_BITS + 2;
    localparam int CNT_W = $clog2(CORDIC_STEPS);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    cordic_mode_t            mode_reg, mode_next;
    logic signed [DATA_W-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [Z_W-1:0]   z_reg, z_next, ang;
    logic                    dir_pos;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        xs        = x_reg >>> cnt_reg;
        ys        = y_reg >>> cnt_reg;
        ang       = $signed(Z_W'(step_angle(int'(cnt_reg), ANGLE_BITS)));
        // Rotation drives z toward zero; vectoring drives y toward zero.
        dir_pos   = (mode_reg == CORDIC_ROTATE) ? !z_reg[Z_W-1] : y_reg[DATA_W-1];
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mode_next = ctrl.mode;
            x_next    = x_in;
            y_next    = y_in;
            z_next    = z_in;
        end
        else if (busy_reg)
        begin
            if (dir_pos)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ----- hdl/diff_drive_odometry_unit.sv -----
// Top level of the differential-drive wheel odometry block.
//
// Each accepted command word carries both raw encoder counts and a millisecond
// timestamp; the block answers with exactly one result word holding the new
// position, heading and both wheel speeds. One word at a time is processed:
// cmd_stall is high from acceptance until the result has been handed to the
// output register. The work of a word is done by the bit-serial divider (one
// quotient bit per cycle for all 50 dividend bits, run once per wheel) and the
// iterative CORDIC (one micro-rotation per cycle, run once for atan2 and once
// for the rotation). When the elapsed time is zero the divisions are skipped.
// When both wheels travel equally the atan2 pass is skipped. The last step
// waits for as long as a previous result is still held in the output register.
// A finished result sits in the output register until taken, so the next
// command word can be accepted while it waits. Configuration writes are taken
// on any cycle with cfg_we high and should only be issued while the block is
// idle.
module diff_drive_odometry_unit
#(
    parameter int ANGLE_BITS   = dd_odo_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = dd_odo_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  dd_odo_pkg::cmd_word_t cmd_word,
    output logic                  res_valid,
    input  logic                  res_stall,
    output dd_odo_pkg::res_word_t res_word,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [23:0]           cfg_data
);
    import dd_odo_pkg::*;

    localparam int Z_W = ANGLE_BITS + 2;

    // Speed from a quotient with the sign of the travel, saturated to 32 bits.
    function automatic logic [31:0] sat_speed(input logic [DIVIDEND_W-1:0] q,
                                              input logic neg);
        logic [DIVIDEND_W-1:0] qq;
        qq = q;
        if (neg)
        begin
            if (qq > DIVIDEND_W'(33'h080000000))
            begin
                qq = DIVIDEND_W'(33'h080000000);
            end
            return 32'(-qq);
        end
        if (qq > DIVIDEND_W'(32'h7FFFFFFF))
        begin
            qq = DIVIDEND_W'(32'h7FFFFFFF);
        end
        return 32'(qq);
    endfunction

    state_t state_reg, state_next;

    // Configuration and odometry state.
    logic [23:0]            dpt_reg, dpt_next;
    logic [19:0]            wb_reg, wb_next;
    logic [31:0]            last_time_reg, last_time_next;
    logic [31:0]            last_left_reg, last_left_next;
    logic [31:0]            last_right_reg, last_right_next;
    logic [POS_W-1:0]       x_acc_reg, x_acc_next;
    logic [POS_W-1:0]       y_acc_reg, y_acc_next;
    logic [ANGLE_BITS-1:0]  heading_reg, heading_next;

    // Per-word working registers.
    logic signed [31:0]        dlt_reg, dlt_next, drt_reg, drt_next;
    logic [DT_W-1:0]           dt_reg, dt_next;
    logic signed [TRAVEL_W-1:0] dl_reg, dl_next, dr_reg, dr_next;
    logic [31:0]               lspd_reg, lspd_next, rspd_reg, rspd_next;
    logic signed [Z_W-1:0]     dtheta_reg, dtheta_next;
    logic signed [DATA_W-1:0]  pre_reg, pre_next;
    logic signed [Z_W-1:0]     zrot_reg, zrot_next;

    // Output register.
    logic      res_valid_reg, res_valid_next;
    res_word_t res_reg, res_next;

    // Shared datapath signals.
    logic signed [31:0]         mul_a;
    logic signed [TRAVEL_W-1:0] mul_p;
    logic signed [TRAVEL_W-1:0] travel;
    logic [TRAVEL_W-1:0]        mag;
    logic [DIVIDEND_W-1:0]      dividend;
    logic signed [SUM_W-1:0]    diff, sum;
    logic [SUM_W-1:0]           diff_abs;
    logic signed [47:0]         mean16;
    logic signed [64:0]         gain_p;
    logic signed [DATA_W-1:0]   pre_raw;
    logic [ANGLE_BITS-1:0]      mid;
    logic signed [Z_W-1:0]      zmid, dtheta_half;
    logic [31:0]                right_now;
    logic                       cmd_accept;

    logic                  div_start, div_done;
    logic [DIVIDEND_W-1:0] div_q;

    cordic_ctrl_t             cor_ctrl;
    logic signed [DATA_W-1:0] cor_x_in, cor_y_in, cor_x, cor_y;
    logic signed [Z_W-1:0]    cor_z_in, cor_z;
    logic                     cor_done;

    dd_odo_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (dt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    dd_odo_cordic
    #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    )
    u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cor_ctrl),
        .x_in  (cor_x_in),
        .y_in  (cor_y_in),
        .z_in  (cor_z_in),
        .done  (cor_done),
        .x_out (cor_x),
        .y_out (cor_y),
        .z_out (cor_z)
    );

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && (state_reg == ST_IDLE);
    assign right_now  = 32'(-cmd_word.right_count_raw);

    // One multiplier serves both wheels: ticks times distance per tick.
    assign mul_a = (state_reg == ST_MUL_L) ? dlt_reg : drt_reg;
    assign mul_p = TRAVEL_W'(mul_a * $signed({1'b0, dpt_reg}));

    // Dividend for the speed: travel magnitude in 2^-8 mm, times 1000.
    assign travel   = (state_reg == ST_SPD_L) ? dl_reg : dr_reg;
    assign mag      = travel[TRAVEL_W-1] ? TRAVEL_W'(-travel) : TRAVEL_W'(travel);
    assign dividend = DIVIDEND_W'(mag[TRAVEL_W-1:16]) * DIVIDEND_W'(MS_PER_S);

    // Heading step input: the travel difference, worked on as a magnitude.
    assign diff     = SUM_W'(dr_reg) - SUM_W'(dl_reg);
    assign diff_abs = diff[SUM_W-1] ? SUM_W'(-diff) : SUM_W'(diff);

    // Mean travel in 2^-16 mm, with the CORDIC gain taken out up front.
    assign sum     = SUM_W'(dl_reg) + SUM_W'(dr_reg);
    assign mean16  = 48'(sum >>> 9);
    assign gain_p  = mean16 * $signed(GAIN_Q16);
    assign pre_raw = DATA_W'(gain_p >>> 16);

    // Mid-step heading is the old heading plus half the step.
    assign dtheta_half = dtheta_reg >>> 1;
    assign mid         = heading_reg + ANGLE_BITS'(dtheta_half);

    always_comb
    begin
        zmid = $signed(Z_W'(mid));
        if (mid[ANGLE_BITS-1])
        begin
            zmid = zmid - $signed(Z_W'(1) << ANGLE_BITS);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        dpt_next        = dpt_reg;
        wb_next         = wb_reg;
        last_time_next  = last_time_reg;
        last_left_next  = last_left_reg;
        last_right_next = last_right_reg;
        x_acc_next      = x_acc_reg;
        y_acc_next      = y_acc_reg;
        heading_next    = heading_reg;
        dlt_next        = dlt_reg;
        drt_next        = drt_reg;
        dt_next         = dt_reg;
        dl_next         = dl_reg;
        dr_next         = dr_reg;
        lspd_next       = lspd_reg;
        rspd_next       = rspd_reg;
        dtheta_next     = dtheta_reg;
        pre_next        = pre_reg;
        zrot_next       = zrot_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        div_start       = 1'b0;
        cor_ctrl.start  = 1'b0;
        cor_ctrl.mode   = CORDIC_VECTOR;
        cor_x_in        = $signed(DATA_W'({wb_reg, 16'd0}));
        cor_y_in        = $signed(DATA_W'(diff_abs));
        cor_z_in        = '0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            if (cfg_index == REG_DIST_PER_TICK)
            begin
                dpt_next = cfg_data;
            end
            else if (cfg_index == REG_WHEEL_BASE)
            begin
                wb_next = cfg_data[19:0];
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    // Deltas wrap modulo 2^32 and read as signed ticks.
                    dlt_next        = $signed(cmd_word.left_count - last_left_reg);
                    drt_next        = $signed(right_now - last_right_reg);
                    dt_next         = cmd_word.now_ms - last_time_reg;
                    last_left_next  = cmd_word.left_count;
                    last_right_next = right_now;
                    last_time_next  = cmd_word.now_ms;
                    state_next      = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                dl_next    = mul_p;
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                dr_next    = mul_p;
                state_next = ST_SPD_L;
            end
            ST_SPD_L:
            begin
                if (dt_reg == '0)
                begin
                    lspd_next  = '0;
                    state_next = ST_SPD_R;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_L;
                end
            end
            ST_DIV_L:
            begin
                if (div_done)
                begin
                    lspd_next  = sat_speed(div_q, dl_reg[TRAVEL_W-1]);
                    state_next = ST_SPD_R;
                end
            end
            ST_SPD_R:
            begin
                if (dt_reg == '0)
                begin
                    rspd_next  = '0;
                    state_next = ST_VEC;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_R;
                end
            end
            ST_DIV_R:
            begin
                if (div_done)
                begin
                    rspd_next  = sat_speed(div_q, dr_reg[TRAVEL_W-1]);
                    state_next = ST_VEC;
                end
            end
            ST_VEC:
            begin
                // Equal travels give a step of exactly zero.
                if (diff_abs == '0)
                begin
                    dtheta_next = '0;
                    state_next  = ST_ROT_PREP;
                end
                else
                begin
                    cor_ctrl.start = 1'b1;
                    cor_ctrl.mode  = CORDIC_VECTOR;
                    state_next     = ST_VEC_WAIT;
                end
            end
            ST_VEC_WAIT:
            begin
                if (cor_done)
                begin
                    dtheta_next = diff[SUM_W-1] ? -cor_z : cor_z;
                    state_next  = ST_ROT_PREP;
                end
            end
            ST_ROT_PREP:
            begin
                heading_next = heading_reg + ANGLE_BITS'(dtheta_reg);
                // Fold the mid angle into a half turn and flip the travel to match.
                if (zmid > $signed(Z_W'(1) << (ANGLE_BITS - 2)))
                begin
                    zrot_next = zmid - $signed(Z_W'(1) << (ANGLE_BITS - 1));
                    pre_next  = -pre_raw;
                end
                else if (zmid < -$signed(Z_W'(1) << (ANGLE_BITS - 2)))
                begin
                    zrot_next = zmid + $signed(Z_W'(1) << (ANGLE_BITS - 1));
                    pre_next  = -pre_raw;
                end
                else
                begin
                    zrot_next = zmid;
                    pre_next  = pre_raw;
                end
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                cor_ctrl.start = 1'b1;
                cor_ctrl.mode  = CORDIC_ROTATE;
                cor_x_in       = pre_reg;
                cor_y_in       = '0;
                cor_z_in       = zrot_reg;
                state_next     = ST_ROT_WAIT;
            end
            ST_ROT_WAIT:
            begin
                if (cor_done)
                begin
                    x_acc_next = x_acc_reg + POS_W'(cor_x);
                    y_acc_next = y_acc_reg + POS_W'(cor_y);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Wait here only while the previous result is still held.
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.pos_x           = $signed(x_acc_reg);
                    res_next.pos_y           = $signed(y_acc_reg);
                    res_next.heading         = 24'(heading_reg);
                    res_next.left_speed      = $signed(lspd_reg);
                    res_next.right_speed     = $signed(rspd_reg);
                    res_next.no_elapsed_time = (dt_reg == '0);
                    res_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            dpt_reg        <= 24'd1048576;
            wb_reg         <= 20'd64000;
            last_time_reg  <= '0;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            x_acc_reg      <= '0;
            y_acc_reg      <= '0;
            heading_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dpt_reg        <= dpt_next;
            wb_reg         <= wb_next;
            last_time_reg  <= last_time_next;
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
            x_acc_reg      <= x_acc_next;
            y_acc_reg      <= y_acc_next;
            heading_reg    <= heading_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dlt_reg    <= dlt_next;
        drt_reg    <= drt_next;
        dt_reg     <= dt_next;
        dl_reg     <= dl_next;
        dr_reg     <= dr_next;
        lspd_reg   <= lspd_next;
        rspd_reg   <= rspd_next;
        dtheta_reg <= dtheta_next;
        pre_reg    <= pre_next;
        zrot_reg   <= zrot_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;

endmodule
